// File: design/lrcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrcd_pkg
// Shared types and constants for the log ring chunk drain block.
// ----------------------------------------------------------------------------
package lrcd_pkg;

  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CHUNK_LIMIT_RST = 7'd64;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FLUSH = 2'd1,
    OP_DRAIN = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  // read issued toward the output pipeline
  typedef struct packed {
    logic vld;
    logic last;
  } rd_tag_t;

endpackage
`default_nettype wire

// File: design/log_ring_chunk_drain.sv
`default_nettype none
// Write, flush and acknowledge never stall; input accepted every cycle outside a drain.
// Drain: each read passes the ring memory read register, then the output register; one
// byte per cycle while out_stall is low; input stalls until the chunk's last read issues.
// Reset (rst_n low, synchronous) clears pointers and pending read; chunk_limit -> 64.
// Ring contents are not cleared; no sweep after reset.
// ----------------------------------------------------------------------------
// log_ring_chunk_drain
// Byte ring buffer with transactional chunk drain and registered output.
// ----------------------------------------------------------------------------
module log_ring_chunk_drain #(
  parameter int unsigned RING_DEPTH = 1024,
  parameter int unsigned CHUNK_MAX  = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_operation,
  input  wire logic [lrcd_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                        in_end_of_write,
  input  wire logic                        in_link_ready,
  input  wire logic                        in_link_taken,
  input  wire logic                        in_accepted,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [lrcd_pkg::BYTE_W-1:0] out_byte,
  output logic                             out_last_of_chunk,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lrcd_pkg::CFG_W-1:0]  cfg_data
);
  import lrcd_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic              adv;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  rd_tag_t           rd_tag;
  rd_tag_t           tag_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              unused_eow;

  assign unused_eow = in_end_of_write;

  // whole read pipeline moves together when the output slot frees up
  assign adv = !out_valid_r || !out_stall;

  lrcd_ctrl #(
    .DEPTH     (RING_DEPTH),
    .AW        (AW),
    .CHUNK_MAX (CHUNK_MAX)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_link_ready (in_link_ready),
    .in_link_taken (in_link_taken),
    .in_accepted   (in_accepted),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .adv           (adv),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .rd_tag        (rd_tag)
  );

  lrcd_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data_byte),
    .re    (adv),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag_r       <= rd_tag;
      out_valid_r <= tag_r.vld && !unused_eow | tag_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= mem_rdata;
      out_last_r <= tag_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_chunk = out_last_r;

endmodule
`default_nettype wire

// File: design/lrcd_ring_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrcd_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lrcd_ring_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [lrcd_pkg::BYTE_W-1:0] wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [lrcd_pkg::BYTE_W-1:0] rdata
);
  import lrcd_pkg::*;

  logic [BYTE_W-1:0] store_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: design/lrcd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrcd_ctrl
// Ring pointers, pending read bookkeeping and chunk read sequencer.
// ----------------------------------------------------------------------------
module lrcd_ctrl #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned AW        = 10,
  parameter int unsigned CHUNK_MAX = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_operation,
  input  wire logic                       in_link_ready,
  input  wire logic                       in_link_taken,
  input  wire logic                       in_accepted,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lrcd_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       adv,
  output logic                            mem_we,
  output logic      [AW-1:0]              mem_waddr,
  output logic      [AW-1:0]              mem_raddr,
  output lrcd_pkg::rd_tag_t               rd_tag
);
  import lrcd_pkg::*;

  localparam int unsigned CW = $clog2(CHUNK_MAX + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [AW-1:0]     pend_r, pend_nxt;
  logic              pv_r, pv_nxt;
  logic [AW-1:0]     p_r, p_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CFG_W-1:0]  limit_r;
  logic [CW-1:0]     limit_eff;
  logic [AW-1:0]     wp_inc;
  logic [AW-1:0]     p_inc;
  logic              accept;
  logic              last_rd;
  op_t               op;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r == ST_DRAIN);
  assign accept    = in_valid && !in_stall;
  assign op        = op_t'(in_operation);
  assign wp_inc    = ring_next(wp_r);
  assign p_inc     = ring_next(p_r);
  assign last_rd   = (p_inc == wp_r) || (rem_r == CW'(1));

  always_comb begin
    if (limit_r == '0) begin
      limit_eff = CW'(1);
    end else if (limit_r > CFG_W'(CHUNK_MAX)) begin
      limit_eff = CW'(CHUNK_MAX);
    end else begin
      limit_eff = limit_r[CW-1:0];
    end
  end

  assign mem_waddr = wp_r;
  assign mem_raddr = p_r;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    pend_nxt  = pend_r;
    pv_nxt    = pv_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    mem_we    = 1'b0;
    rd_tag    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE: begin
              if (wp_inc != rp_r) begin
                mem_we = 1'b1;
                wp_nxt = wp_inc;
              end
            end
            OP_FLUSH: begin
              rp_nxt = wp_r;
              pv_nxt = 1'b0;
            end
            OP_DRAIN: begin
              if (!in_link_ready) begin
                rp_nxt = wp_r;
                pv_nxt = 1'b0;
              end else if (!in_link_taken) begin
                if (rp_r == wp_r) begin
                  pv_nxt = 1'b0;
                end else begin
                  p_nxt     = rp_r;
                  rem_nxt   = limit_eff;
                  state_nxt = ST_DRAIN;
                end
              end
            end
            OP_ACK: begin
              if (pv_r && in_accepted) begin
                rp_nxt = pend_r;
              end
              pv_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (adv) begin
          rd_tag.vld  = 1'b1;
          rd_tag.last = last_rd;
          p_nxt       = p_inc;
          rem_nxt     = rem_r - CW'(1);
          if (last_rd) begin
            pend_nxt  = p_inc;
            pv_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      pend_r  <= '0;
      pv_r    <= 1'b0;
      limit_r <= CHUNK_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      pend_r  <= pend_nxt;
      pv_r    <= pv_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    rem_r <= rem_nxt;
  end

endmodule
`default_nettype wire
